[hw/rtl/afc_pkg.sv]
// Shared types and constants for the six-plane box culling block.
// No dependencies; used by afc_cell and aabb_frustum_cull_test.
package afc_pkg;

    // Field widths of the box transaction
    localparam int unsigned COORD_W     = 16;
    localparam int unsigned HALF_W      = COORD_W - 1;

    // Plane register layout: four signed coefficients a, b, c, d (a lowest)
    localparam int unsigned COEF_W      = 16;
    localparam int unsigned PLANE_W     = 4 * COEF_W;
    localparam int unsigned PLANE_COUNT = 6;
    localparam int unsigned CFG_IDX_W   = 3;

    // Arithmetic widths inside a cell
    localparam int unsigned PROD_W      = COORD_W + COEF_W;      // centre times coefficient
    localparam int unsigned RAD_W       = HALF_W + COEF_W;       // half-extent times |coefficient|
    localparam int unsigned SUM_W       = PROD_W + 3;            // M +/- N without overflow

    // Coefficient slots in a plane register
    localparam int unsigned COEF_A      = 0;
    localparam int unsigned COEF_B      = 1;
    localparam int unsigned COEF_C      = 2;
    localparam int unsigned COEF_D      = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] centre_x;
        logic signed [COORD_W-1:0] centre_y;
        logic signed [COORD_W-1:0] centre_z;
        logic        [HALF_W-1:0]  half_x;
        logic        [HALF_W-1:0]  half_y;
        logic        [HALF_W-1:0]  half_z;
    } box_t;

    typedef struct packed {
        logic                   in_view;
        logic [PLANE_COUNT-1:0] straddle_mask;
    } result_t;

    // What one cell hands to the next
    typedef struct packed {
        logic                   valid;
        logic                   visible;
        logic [PLANE_COUNT-1:0] mask;
        box_t                   box;
    } chain_t;

endpackage

[hw/rtl/afc_cell.sv]
// One plane cell of the culling chain: holds one plane register and tests a box against it.
// Depends on afc_pkg.
module afc_cell #(
    parameter int unsigned PLANE_IDX = 0
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic                           cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afc_pkg::PLANE_W-1:0]    cfg_data,
    input  afc_pkg::chain_t                chain_in,
    output afc_pkg::chain_t                chain_out
);
    import afc_pkg::*;

    localparam logic [CFG_IDX_W-1:0]   MY_INDEX = CFG_IDX_W'(PLANE_IDX);
    localparam logic [PLANE_COUNT-1:0] MY_BIT   = PLANE_COUNT'(1) << PLANE_IDX;

    logic [PLANE_W-1:0] plane_reg;

    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic        [COEF_W-1:0] mag_a;
    logic        [COEF_W-1:0] mag_b;
    logic        [COEF_W-1:0] mag_c;

    // Stage one: products
    logic                     valid1_reg;
    logic                     visible1_reg;
    logic [PLANE_COUNT-1:0]   mask1_reg;
    box_t                     box1_reg;
    logic signed [PROD_W-1:0] prod_x_reg, prod_x_next;
    logic signed [PROD_W-1:0] prod_y_reg, prod_y_next;
    logic signed [PROD_W-1:0] prod_z_reg, prod_z_next;
    logic        [RAD_W-1:0]  rad_x_reg, rad_x_next;
    logic        [RAD_W-1:0]  rad_y_reg, rad_y_next;
    logic        [RAD_W-1:0]  rad_z_reg, rad_z_next;
    logic signed [COEF_W-1:0] offset_reg;

    // Stage two: sums and sign tests
    logic signed [SUM_W-1:0]  m_sum;
    logic        [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  far_sum;
    logic signed [SUM_W-1:0]  near_sum;
    logic                     reject;
    logic                     straddle;

    logic                     valid2_reg;
    logic                     visible2_reg, visible2_next;
    logic [PLANE_COUNT-1:0]   mask2_reg, mask2_next;
    box_t                     box2_reg;

    // Hold this cell's plane; writes to other indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
        end else if (cfg_we && (cfg_index == MY_INDEX)) begin
            plane_reg <= cfg_data;
        end
    end

    // Unpack coefficients and their magnitudes
    always_comb begin
        coef_a = plane_reg[COEF_A*COEF_W +: COEF_W];
        coef_b = plane_reg[COEF_B*COEF_W +: COEF_W];
        coef_c = plane_reg[COEF_C*COEF_W +: COEF_W];
        coef_d = plane_reg[COEF_D*COEF_W +: COEF_W];
        mag_a  = coef_a[COEF_W-1] ? (~coef_a + 1'b1) : coef_a;
        mag_b  = coef_b[COEF_W-1] ? (~coef_b + 1'b1) : coef_b;
        mag_c  = coef_c[COEF_W-1] ? (~coef_c + 1'b1) : coef_c;
    end

    // Form the centre products and the projected radius terms
    always_comb begin
        prod_x_next = PROD_W'(coef_a) * PROD_W'($signed(chain_in.box.centre_x));
        prod_y_next = PROD_W'(coef_b) * PROD_W'($signed(chain_in.box.centre_y));
        prod_z_next = PROD_W'(coef_c) * PROD_W'($signed(chain_in.box.centre_z));
        rad_x_next  = RAD_W'(chain_in.box.half_x) * RAD_W'(mag_a);
        rad_y_next  = RAD_W'(chain_in.box.half_y) * RAD_W'(mag_b);
        rad_z_next  = RAD_W'(chain_in.box.half_z) * RAD_W'(mag_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (advance) begin
            valid1_reg <= chain_in.valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            visible1_reg <= chain_in.visible;
            mask1_reg    <= chain_in.mask;
            box1_reg     <= chain_in.box;
            prod_x_reg   <= prod_x_next;
            prod_y_reg   <= prod_y_next;
            prod_z_reg   <= prod_z_next;
            rad_x_reg    <= rad_x_next;
            rad_y_reg    <= rad_y_next;
            rad_z_reg    <= rad_z_next;
            offset_reg   <= coef_d;
        end
    end

    // Sum M and N, test M+N and M-N against zero
    always_comb begin
        m_sum    = SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg) + SUM_W'(prod_z_reg)
                 + SUM_W'(offset_reg);
        n_sum    = SUM_W'(rad_x_reg) + SUM_W'(rad_y_reg) + SUM_W'(rad_z_reg);
        far_sum  = m_sum + signed'(n_sum);
        near_sum = m_sum - signed'(n_sum);
        reject   = far_sum[SUM_W-1];
        straddle = near_sum[SUM_W-1];
    end

    // Mark the box not visible at the first rejecting plane; later cells only pass that verdict on
    always_comb begin
        visible2_next = visible1_reg && !reject;
        mask2_next    = mask1_reg;
        if (visible1_reg && !reject && straddle) begin
            mask2_next = mask1_reg | MY_BIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            visible2_reg <= visible2_next;
            mask2_reg    <= mask2_next;
            box2_reg     <= box1_reg;
        end
    end

    assign chain_out.valid   = valid2_reg;
    assign chain_out.visible = visible2_reg;
    assign chain_out.mask    = mask2_reg;
    assign chain_out.box     = box2_reg;

endmodule

[hw/rtl/aabb_frustum_cull_test.sv]
// Top level of the six-plane box culling block: plane configuration and the cell chain.
// Depends on afc_pkg and afc_cell.
//
// Accepts one box transaction per cycle unless the result stalls, and returns one result
// per box, in order. Six plane cells in a row, each with a product and a sum-and-compare
// stage. The chain advances as a whole; when the result is not taken the entire chain
// holds and s_ready drops in the same cycle. The user must write plane registers through
// cfg_we/cfg_index/cfg_data only while no box is in flight; the block does not enforce
// this. Index six or seven is ignored. Arithmetic is exact, so results never saturate.
module aabb_frustum_cull_test (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  afc_pkg::box_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output afc_pkg::result_t               m_data,
    input  logic                           cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afc_pkg::PLANE_W-1:0]    cfg_data
);
    import afc_pkg::*;

    chain_t link [0:PLANE_COUNT];
    logic   advance;

    // Advance the chain whenever the output slot is free or being emptied
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    // Feed a fresh transaction: visible until some plane rejects it
    assign link[0].valid   = s_valid;
    assign link[0].visible = 1'b1;
    assign link[0].mask    = '0;
    assign link[0].box     = s_data;

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
        afc_cell #(
            .PLANE_IDX (p)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .cfg_we    (cfg_we),
            .cfg_index (cfg_index),
            .cfg_data  (cfg_data),
            .chain_in  (link[p]),
            .chain_out (link[p+1])
        );
    end

    // Last cell's stage two is the output register
    assign m_valid              = link[PLANE_COUNT].valid;
    assign m_data.in_view       = link[PLANE_COUNT].visible;
    assign m_data.straddle_mask = link[PLANE_COUNT].mask;

    // A stalled result must also stall the input side
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while result stalled");

    // A rejected box never reaches the last plane as straddling
    a_reject_last_plane: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.in_view) |-> !m_data.straddle_mask[PLANE_COUNT-1])
        else $error("rejected box carries a straddle bit for the last plane");

    // Chain is empty right after reset
    a_empty_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // A held result keeps its value while stalled
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

[sim/aabb_frustum_cull_test_test.sv]
// Self-checking testbench for the six-plane box culling block (aabb_frustum_cull_test).
// Depends on afc_pkg for the box and result types and the plane register layout.
// An internal culling predictor supplies the expected verdicts; random gaps and stalls vary timing.
module aabb_frustum_cull_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    import afc_pkg::*;

    localparam int PIPE_DEPTH  = 12;
    localparam int LONG_STALL  = 400;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY} rx_style_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    box_t                 s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    result_t              m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PLANE_W-1:0]   cfg_data  = '0;

    // Predictor copy of the plane registers and the planes staged for the next load
    logic [PLANE_W-1:0]   plane_regs [PLANE_COUNT];
    logic [PLANE_W-1:0]   next_planes[PLANE_COUNT];
    result_t              pending_verdicts[$];
    result_t              want_verdict;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;

    // Receiver state
    rx_style_t            rx_style = RX_STEADY;
    logic                 stall_tog = 1'b0;
    logic                 stall_seen = 1'b0;
    int                   hold_left = 0;
    int                   run_left = 0;
    logic                 rdy_phase = 1'b0;

    aabb_frustum_cull_test u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("aabb_frustum_cull_test_test NOT OK");
            $finish;
        end
    end

    // Cull one box against the current planes: first plane with M+N < 0 rejects,
    // planes passed before that flag a straddle when M-N < 0
    function automatic result_t cull_box(box_t b);
        result_t verdict;
        longint  ctr[3];
        longint  half[3];
        longint  centre_dist;
        longint  rad;
        longint  coef;
        verdict.in_view       = 1'b1;
        verdict.straddle_mask = '0;
        ctr[0]  = $signed(b.centre_x);
        ctr[1]  = $signed(b.centre_y);
        ctr[2]  = $signed(b.centre_z);
        half[0] = longint'(b.half_x);
        half[1] = longint'(b.half_y);
        half[2] = longint'(b.half_z);
        for (int p = 0; p < PLANE_COUNT; p++) begin
            centre_dist = $signed(plane_regs[p][COEF_D*COEF_W +: COEF_W]);
            rad  = 0;
            for (int k = 0; k < 3; k++) begin
                coef = $signed(plane_regs[p][k*COEF_W +: COEF_W]);
                centre_dist += coef * ctr[k];
                rad  += half[k] * (coef < 0 ? -coef : coef);
            end
            if (centre_dist + rad < 0) begin
                verdict.in_view = 1'b0;
                break;
            end
            if (centre_dist - rad < 0)
                verdict.straddle_mask[p] = 1'b1;
        end
        return verdict;
    endfunction

    function automatic logic [PLANE_W-1:0] plane_of(int a, int b, int c, int d);
        return {d[COEF_W-1:0], c[COEF_W-1:0], b[COEF_W-1:0], a[COEF_W-1:0]};
    endfunction

    function automatic box_t box_of(int cx, int cy, int cz, int hx, int hy, int hz);
        box_t b;
        b.centre_x = COORD_W'(cx);
        b.centre_y = COORD_W'(cy);
        b.centre_z = COORD_W'(cz);
        b.half_x   = HALF_W'(hx);
        b.half_y   = HALF_W'(hy);
        b.half_z   = HALF_W'(hz);
        return b;
    endfunction

    // Coefficient with a bias toward the extremes and toward small values
    function automatic int any_coef();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return int'($urandom_range(0, 16)) - 8;
            default: return int'($urandom);
        endcase
    endfunction

    // Span 0 means full-range fields; otherwise a box near the origin
    function automatic box_t random_box(int span);
        box_t b;
        if (span == 0) begin
            b = box_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            b = box_of(int'($urandom_range(0, 2*span)) - span,
                       int'($urandom_range(0, 2*span)) - span,
                       int'($urandom_range(0, 2*span)) - span,
                       $urandom_range(0, span/3), $urandom_range(0, span/3),
                       $urandom_range(0, span/3));
            if ($urandom_range(0, 15) == 0)
                b.half_x = HALF_W'($urandom);
        end
        return b;
    endfunction

    // Stage six planes bounding a random box region, each facing inward mostly along one axis
    function automatic void stage_region(bit allow_zero);
        int w[3];
        int k;
        int reach;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            k     = $urandom_range(1, 64);
            reach = $urandom_range(20, 300);
            for (int q = 0; q < 3; q++)
                w[q] = int'($urandom_range(0, 6)) - 3;
            w[p/2] = (p % 2) ? -k : k;
            next_planes[p] = plane_of(w[0], w[1], w[2], k * reach);
            if (allow_zero && $urandom_range(0, 3) == 0)
                next_planes[p] = '0;
        end
    endfunction

    // Receiver: always ready or random ready/stall runs by style, plus a long hold-off on request
    always @(posedge aclk) begin
        if (stall_tog != stall_seen) begin
            stall_seen = stall_tog;
            hold_left  = LONG_STALL;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_style == RX_STEADY) begin
            m_ready <= 1'b1;
        end else begin
            if (run_left == 0) begin
                rdy_phase = ~rdy_phase;
                run_left  = rdy_phase ? $urandom_range(1, 8)
                                      : $urandom_range(1, rx_style == RX_HEAVY ? 12 : 3);
            end
            run_left--;
            m_ready <= rdy_phase;
        end
    end

    // Compare each accepted result with the oldest pending verdict
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: in_view=%0b straddle_mask=%06b",
                       m_data.in_view, m_data.straddle_mask);
                mismatch_count++;
            end else begin
                want_verdict = pending_verdicts.pop_front();
                if (m_data.in_view !== want_verdict.in_view) begin
                    $error("in_view: expected %0b, got %0b",
                           want_verdict.in_view, m_data.in_view);
                    mismatch_count++;
                end
                if (m_data.straddle_mask !== want_verdict.straddle_mask) begin
                    $error("straddle_mask: expected %06b, got %06b",
                           want_verdict.straddle_mask, m_data.straddle_mask);
                    mismatch_count++;
                end
            end
        end
    end

    // Offer one box, hold it until accepted, then record its verdict
    task automatic offer_box(box_t b);
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_verdicts.push_back(cull_box(b));
    endtask

    // Idle the sender; a zero-length gap keeps valid up
    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every verdict has come back
    task automatic settle_block();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic write_reg(int idx, logic [PLANE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= value;
        @(posedge aclk);
        if (idx < PLANE_COUNT)
            plane_regs[idx] = value;
    endtask

    task automatic commit_planes();
        for (int p = 0; p < PLANE_COUNT; p++)
            write_reg(p, next_planes[p]);
        cfg_we <= 1'b0;
    endtask

    // Send boxes in bursts of random length, with random gaps if asked
    task automatic stream_boxes(int count, int span, bit bursty);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && left > 0; i++) begin
                offer_box(random_box(span));
                left--;
            end
            if (bursty)
                pause_sender($urandom_range(0, 6));
        end
    endtask

    // Reset planes are all zero: nothing rejects or straddles; stray indexes change nothing
    task automatic test_zero_planes();
        write_reg(PLANE_COUNT, '1);
        write_reg(PLANE_COUNT + 1, 64'h8000_7fff_8000_7fff);
        cfg_we <= 1'b0;
        offer_box(box_of(-32768, -32768, -32768, 0, 0, 0));
        offer_box(box_of(32767, 32767, 32767, 32767, 32767, 32767));
        offer_box(box_of(0, -1, 1, 32767, 0, 1));
        offer_box(box_of(-32768, 32767, 0, 16384, 16383, 32767));
        settle_block();
    endtask

    // Straddles before a rejecting plane survive; later planes add nothing
    task automatic test_straddle_then_reject();
        next_planes[0] = plane_of(1, 0, 0, 0);
        next_planes[1] = plane_of(0, 1, 0, 0);
        next_planes[2] = plane_of(0, 0, 1, 0);
        next_planes[3] = plane_of(0, 0, 0, -1);
        next_planes[4] = plane_of(-1, 0, 0, 0);
        next_planes[5] = '0;
        commit_planes();
        offer_box(box_of(0, 0, 0, 5, 5, 5));
        offer_box(box_of(10, 10, 10, 5, 5, 5));
        offer_box(box_of(-10, 0, 0, 5, 5, 5));
        settle_block();
        // Make plane 3 pass so planes 4 and 5 are reached
        next_planes[3] = plane_of(0, 0, 0, 1);
        commit_planes();
        offer_box(box_of(0, 0, 0, 5, 5, 5));
        offer_box(box_of(2, 3, 4, 1, 1, 1));
        settle_block();
    endtask

    // Extreme coefficients against extreme centres and half-extents
    task automatic test_extreme_values();
        next_planes[0] = plane_of(-32768, -32768, -32768, -32768);
        for (int p = 1; p < PLANE_COUNT; p++)
            next_planes[p] = plane_of(32767, 32767, 32767, 32767);
        commit_planes();
        offer_box(box_of(-32768, -32768, -32768, 0, 0, 0));
        offer_box(box_of(32767, 32767, 32767, 0, 0, 0));
        offer_box(box_of(-32768, -32768, -32768, 32767, 32767, 32767));
        offer_box(box_of(32767, 32767, 32767, 32767, 32767, 32767));
        next_planes[0] = plane_of(32767, -32768, 32767, 32767);
        next_planes[5] = plane_of(-32768, 32767, -32768, -32768);
        settle_block();
        commit_planes();
        offer_box(box_of(32767, -32768, 32767, 32767, 0, 32767));
        offer_box(box_of(-32768, 32767, -32768, 0, 32767, 0));
        settle_block();
    endtask

    // Region planes: boxes fall inside, outside and across every plane
    task automatic test_region_traffic();
        stage_region(1'b0);
        commit_planes();
        rx_style = RX_LIGHT;
        stream_boxes(100, 400, 1'b1);
        settle_block();
        // Hold a stretch without any idling on either side
        stage_region(1'b1);
        commit_planes();
        rx_style = RX_STEADY;
        stream_boxes(80, 400, 1'b0);
        settle_block();
        stage_region(1'b0);
        commit_planes();
        rx_style = RX_HEAVY;
        stream_boxes(100, 300, 1'b1);
        settle_block();
    endtask

    // Arbitrary planes and full-range boxes
    task automatic test_random_planes();
        for (int p = 0; p < PLANE_COUNT; p++)
            next_planes[p] = plane_of(any_coef(), any_coef(), any_coef(), any_coef());
        commit_planes();
        rx_style = RX_LIGHT;
        stream_boxes(60, 0, 1'b1);
        settle_block();
        for (int p = 0; p < PLANE_COUNT; p++)
            next_planes[p] = plane_of($urandom_range(0, 1) ? 32767 : -32768,
                                      $urandom_range(0, 1) ? 32767 : -32768,
                                      $urandom_range(0, 1) ? 32767 : -32768,
                                      $urandom_range(0, 1) ? 32767 : -32768);
        commit_planes();
        rx_style = RX_HEAVY;
        stream_boxes(40, 0, 1'b1);
        settle_block();
    endtask

    // Hold the result side off long enough for the chain to fill and stall the input
    task automatic test_back_pressure();
        stage_region(1'b0);
        commit_planes();
        rx_style = RX_LIGHT;
        stall_tog <= ~stall_tog;
        stream_boxes(60, 400, 1'b0);
        settle_block();
    endtask

    initial begin
        for (int p = 0; p < PLANE_COUNT; p++)
            plane_regs[p] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_planes();
        test_straddle_then_reject();
        test_extreme_values();
        test_region_traffic();
        test_random_planes();
        test_back_pressure();
        if (mismatch_count == 0)
            $display("aabb_frustum_cull_test_test OK");
        else
            $display("aabb_frustum_cull_test_test NOT OK");
        $finish;
    end

endmodule
